>>> rtl/core/olag_pkg.sv
// ----------------------------------------------------------------------------
// olag_pkg
// Shared constants, codes and request types of the orbit interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package olag_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int WINDOW_POINTS = 8;
  localparam int WIN_PRE       = (WINDOW_POINTS - 1) / 2;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = AW + 1;
  localparam int WI_W  = $clog2(WINDOW_POINTS);

  localparam int T_W    = 52;           // time, 20 fractional bits
  localparam int P_W    = 48;           // position, 16 fractional bits
  localparam int PM_W   = P_W + 1;      // position magnitude
  localparam int ROW_W  = 3 * P_W;      // x, y, z of one sample
  localparam int W_W    = 47;           // weight / ratio magnitude
  localparam int FRAC_S = 32;           // fraction bits of weights
  localparam int DIVN_W = T_W + FRAC_S; // divider dividend and quotient
  localparam int MUL_H  = 25;
  localparam int MUL_W  = 2 * MUL_H;
  localparam int PROD_W = 2 * MUL_W;
  localparam int V_W    = PROD_W - FRAC_S;
  localparam int TERM_W = 59;
  localparam int ACC_W  = 64;

  localparam int IN_TD_W  = 200;        // 52 + 3*48 = 196, padded to bytes
  localparam int OUT_TD_W = 144;

  localparam logic [W_W-1:0]    WMAX     = {W_W{1'b1}};
  localparam logic [TERM_W-1:0] TERM_MAX = TERM_W'(1) << 58;
  localparam logic signed [ACC_W-1:0] POS_MAX = ACC_W'(64'sh0000_7FFF_FFFF_FFFF);
  localparam logic signed [ACC_W-1:0] POS_MIN = -ACC_W'(64'sh0000_8000_0000_0000);

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FEW   = 2'd3;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [T_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

>>> rtl/core/olag_ram.sv
// ----------------------------------------------------------------------------
// olag_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module olag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/olag_div.sv
// ----------------------------------------------------------------------------
// olag_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module olag_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire olag_pkg::div_req_t         req,
  output logic                            done,
  output logic [olag_pkg::DIVN_W-1:0]     quo
);
  import olag_pkg::*;

  localparam int CW = $clog2(DIVN_W);

  logic [T_W-1:0]    rem_r;
  logic [DIVN_W-1:0] quo_r;
  logic [T_W-1:0]    den_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [T_W:0] shifted;
  logic         fits;

  assign shifted = {rem_r, quo_r[DIVN_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIVN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      den_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? T_W'(shifted - {1'b0, den_r}) : shifted[T_W-1:0];
      quo_r <= {quo_r[DIVN_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

>>> rtl/core/olag_mul.sv
// ----------------------------------------------------------------------------
// olag_mul
// Unsigned multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module olag_mul (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire olag_pkg::mul_req_t         req,
  output logic                            done,
  output logic [olag_pkg::PROD_W-1:0]     prod
);
  import olag_pkg::*;

  logic [MUL_W-1:0]   a_r;
  logic [MUL_W-1:0]   b_r;
  logic [PROD_W-1:0]  acc_r;
  logic [MUL_W-1:0]   pp_r;
  logic [1:0]         sh_r;
  logic               pv_r;
  logic [2:0]         cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [MUL_H-1:0]   a_sel;
  logic [MUL_H-1:0]   b_sel;
  logic [PROD_W-1:0]  pp_shift;

  assign a_sel = cnt_r[1] ? a_r[MUL_W-1:MUL_H] : a_r[MUL_H-1:0];
  assign b_sel = cnt_r[0] ? b_r[MUL_W-1:MUL_H] : b_r[MUL_H-1:0];

  always_comb begin
    unique case (sh_r)
      2'd0:    pp_shift = PROD_W'(pp_r);
      2'd1:    pp_shift = PROD_W'(pp_r) << MUL_H;
      default: pp_shift = PROD_W'(pp_r) << MUL_W;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pv_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        pv_r   <= 1'b0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        pv_r  <= !cnt_r[2];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r[2]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      pp_r <= a_sel * b_sel;
      sh_r <= 2'(cnt_r[1]) + 2'(cnt_r[0]);
      if (pv_r) begin
        acc_r <= acc_r + pp_shift;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

>>> rtl/core/orbit_lagrange_interpolator_top.sv
// Append, clear and unused kinds pass straight to S_POST, which loads the output register.
// Query: time to out_tvalid is set by the bit-serial divider (57 divisions) and the
// four-partial-product multiplier (80 products); range and count rejects end the query
// early, and a repeated time ends the query at the pair where it is found.
// Throughput: one item at a time; a new item is taken while the last result waits.
// Reset: synchronous active-low; clears sample count and handshake, not the tables.
// ----------------------------------------------------------------------------
// orbit_lagrange_interpolator_top
// Orbit sample table with eight-point Lagrange position interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module orbit_lagrange_interpolator_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // sample_time, pos_x_in, pos_y_in, pos_z_in, zero pad
  input  wire logic [olag_pkg::IN_TD_W-1:0]  in_tdata,
  // kind
  input  wire logic [1:0]                    in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // pos_x_out, pos_y_out, pos_z_out
  output logic [olag_pkg::OUT_TD_W-1:0]      out_tdata,
  // status
  output logic [1:0]                         out_tuser
);
  import olag_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RD0    = 5'd1;
  localparam logic [4:0] S_RD1    = 5'd2;
  localparam logic [4:0] S_BASE   = 5'd3;
  localparam logic [4:0] S_TI_REQ = 5'd4;
  localparam logic [4:0] S_TI     = 5'd5;
  localparam logic [4:0] S_TJ_REQ = 5'd6;
  localparam logic [4:0] S_TJ     = 5'd7;
  localparam logic [4:0] S_DIV    = 5'd8;
  localparam logic [4:0] S_MUL    = 5'd9;
  localparam logic [4:0] S_NEXT   = 5'd10;
  localparam logic [4:0] S_PR_REQ = 5'd11;
  localparam logic [4:0] S_PR     = 5'd12;
  localparam logic [4:0] S_TM     = 5'd13;
  localparam logic [4:0] S_TMW    = 5'd14;
  localparam logic [4:0] S_FIN    = 5'd15;
  localparam logic [4:0] S_POST   = 5'd16;

  localparam logic [WI_W-1:0] I_LAST = WI_W'(WINDOW_POINTS - 1);

  logic [4:0]        state_r;
  logic [CNT_W-1:0]  count_r;
  logic [1:0]        status_r;
  logic [T_W-1:0]    t_r;
  logic [T_W-1:0]    t0_r;
  logic [T_W-1:0]    ti_r;
  logic [AW-1:0]     start_r;
  logic [WI_W-1:0]   i_r;
  logic [WI_W-1:0]   j_r;
  logic [1:0]        c_r;
  logic [W_W-1:0]    w_cur_r;
  logic              wneg_cur_r;
  logic              sneg_r;
  logic [W_W-1:0]    w_mag_r [WINDOW_POINTS];
  logic              w_neg_r [WINDOW_POINTS];
  logic [ROW_W-1:0]  p_row_r;
  logic signed [ACC_W-1:0] acc_r [3];
  logic [P_W-1:0]    res_r [3];

  logic              out_tvalid_r;
  logic [1:0]        out_status_r;
  logic [OUT_TD_W-1:0] out_data_r;

  // input fields
  logic [1:0]        in_kind;
  logic [T_W-1:0]    in_time;
  logic [ROW_W-1:0]  in_row;
  logic              in_acc;
  logic              out_free;

  // memories
  logic              tab_we;
  logic [AW-1:0]     time_raddr;
  logic [T_W-1:0]    t_rd;
  logic [ROW_W-1:0]  row_rd;

  // arithmetic
  div_req_t          div_req;
  logic              div_done;
  logic [DIVN_W-1:0] div_quo;
  mul_req_t          mul_req;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;

  logic              bad01;
  logic              nn;
  logic              dn;
  logic [T_W-1:0]    nm;
  logic [T_W-1:0]    dm;
  logic [W_W-1:0]    ratio;
  logic [DIVN_W:0]   win_end;
  logic              base_low;
  logic              base_high;
  logic [V_W-1:0]    mul_v;
  logic [W_W-1:0]    w_sat;
  logic [TERM_W-1:0] term;
  logic [P_W-1:0]    p_sel;
  logic [PM_W-1:0]   pm;
  logic              pn;
  logic [AW-1:0]     addr_i;
  logic [AW-1:0]     addr_j;

  assign in_kind  = in_tuser;
  assign in_time  = in_tdata[T_W-1:0];
  assign in_row   = in_tdata[T_W+ROW_W-1:T_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  assign tab_we = in_acc && (in_kind == KIND_APPEND) && (count_r < CNT_W'(TABLE_DEPTH));
  assign addr_i = start_r + AW'(i_r);
  assign addr_j = start_r + AW'(j_r);

  always_comb begin
    unique case (state_r)
      S_RD0:    time_raddr = AW'(1);
      S_TI_REQ: time_raddr = addr_i;
      S_TJ_REQ: time_raddr = addr_j;
      default:  time_raddr = '0;
    endcase
  end

  olag_ram #(.WIDTH(T_W), .DEPTH(TABLE_DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_time),
    .raddr (time_raddr),
    .rdata (t_rd)
  );

  olag_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_row),
    .raddr (addr_i),
    .rdata (row_rd)
  );

  // time differences
  assign bad01 = (t_rd <= t0_r) || (t_r < t0_r);
  assign nn    = t_r < t_rd;
  assign nm    = nn ? t_rd - t_r : t_r - t_rd;
  assign dn    = ti_r < t_rd;
  assign dm    = dn ? t_rd - ti_r : ti_r - t_rd;

  always_comb begin
    div_req.start    = ((state_r == S_RD1) && !bad01) || ((state_r == S_TJ) && (dm != '0));
    div_req.dividend = (state_r == S_RD1) ? DIVN_W'(t_r - t0_r) : {nm, {FRAC_S{1'b0}}};
    div_req.divisor  = (state_r == S_RD1) ? t_rd - t0_r : dm;
  end

  olag_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign ratio     = (div_quo > DIVN_W'(WMAX)) ? WMAX : div_quo[W_W-1:0];
  assign win_end   = {1'b0, div_quo} + (DIVN_W+1)'(WINDOW_POINTS - WIN_PRE);
  assign base_low  = div_quo < DIVN_W'(WIN_PRE);
  assign base_high = win_end > (DIVN_W+1)'(count_r);

  // position magnitude; the most negative code maps to 2^48
  always_comb begin
    unique case (c_r)
      2'd0:    p_sel = p_row_r[P_W-1:0];
      2'd1:    p_sel = p_row_r[2*P_W-1:P_W];
      default: p_sel = p_row_r[3*P_W-1:2*P_W];
    endcase
    pn = p_sel[P_W-1];
    if (p_sel == {1'b1, {(P_W-1){1'b0}}}) begin
      pm = PM_W'(1) << P_W;
    end else if (pn) begin
      pm = {1'b0, P_W'(-p_sel)};
    end else begin
      pm = PM_W'(p_sel);
    end
  end

  always_comb begin
    mul_req.start = ((state_r == S_DIV) && div_done) || (state_r == S_TM);
    mul_req.a     = (state_r == S_DIV) ? MUL_W'(w_cur_r) : MUL_W'(pm);
    mul_req.b     = (state_r == S_DIV) ? MUL_W'(ratio) : MUL_W'(w_mag_r[i_r]);
  end

  olag_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign mul_v = mul_prod[PROD_W-1:FRAC_S];
  assign w_sat = (mul_v > V_W'(WMAX)) ? WMAX : mul_v[W_W-1:0];
  assign term  = (mul_v > V_W'(TERM_MAX)) ? TERM_MAX : mul_v[TERM_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_kind == KIND_QUERY) begin
              state_r <= (count_r < CNT_W'(2)) ? S_POST : S_RD0;
            end else begin
              state_r <= S_POST;
            end
            if (tab_we) begin
              count_r <= count_r + 1'b1;
            end else if (in_kind == KIND_CLEAR) begin
              count_r <= '0;
            end
          end
        end
        S_RD0:    state_r <= S_RD1;
        S_RD1:    state_r <= bad01 ? S_POST : S_BASE;
        S_BASE: begin
          if (div_done) begin
            state_r <= (base_low || base_high) ? S_POST : S_TI_REQ;
          end
        end
        S_TI_REQ: state_r <= S_TI;
        S_TI:     state_r <= S_TJ_REQ;
        S_TJ_REQ: state_r <= (j_r == i_r) ? S_NEXT : S_TJ;
        S_TJ:     state_r <= (dm == '0) ? S_POST : S_DIV;
        S_DIV:    if (div_done) state_r <= S_MUL;
        S_MUL:    if (mul_done) state_r <= S_NEXT;
        S_NEXT: begin
          if (j_r == I_LAST) begin
            state_r <= (i_r == I_LAST) ? S_PR_REQ : S_TI_REQ;
          end else begin
            state_r <= S_TJ_REQ;
          end
        end
        S_PR_REQ: state_r <= S_PR;
        S_PR:     state_r <= S_TM;
        S_TM:     state_r <= S_TMW;
        S_TMW: begin
          if (mul_done) begin
            if (c_r != 2'd2) begin
              state_r <= S_TM;
            end else begin
              state_r <= (i_r == I_LAST) ? S_FIN : S_PR_REQ;
            end
          end
        end
        S_FIN:    state_r <= S_POST;
        S_POST:   if (out_free) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          t_r    <= in_time;
          res_r  <= '{default: '0};
          if (in_kind == KIND_QUERY) begin
            status_r <= (count_r < CNT_W'(2)) ? ST_FEW : ST_OK;
          end else if (in_kind == KIND_APPEND && !tab_we) begin
            status_r <= ST_FULL;
          end else begin
            status_r <= ST_OK;
          end
        end
      end
      S_RD0: t0_r <= t_rd;
      S_RD1: if (bad01) status_r <= ST_RANGE;
      S_BASE: begin
        if (div_done) begin
          if (base_low || base_high) status_r <= ST_RANGE;
          start_r <= AW'(div_quo - DIVN_W'(WIN_PRE));
          i_r     <= '0;
        end
      end
      S_TI: begin
        ti_r       <= t_rd;
        w_cur_r    <= W_W'(1) << FRAC_S;
        wneg_cur_r <= 1'b0;
        j_r        <= '0;
      end
      S_TJ: begin
        // a repeated time in the window has no weight
        if (dm == '0) status_r <= ST_RANGE;
        sneg_r <= nn ^ dn;
      end
      S_MUL: begin
        if (mul_done) begin
          w_cur_r    <= w_sat;
          wneg_cur_r <= wneg_cur_r ^ sneg_r;
        end
      end
      S_NEXT: begin
        if (j_r == I_LAST) begin
          w_mag_r[i_r] <= w_cur_r;
          w_neg_r[i_r] <= wneg_cur_r;
          i_r          <= (i_r == I_LAST) ? '0 : i_r + 1'b1;
          if (i_r == I_LAST) acc_r <= '{default: '0};
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      S_PR: begin
        p_row_r <= row_rd;
        c_r     <= 2'd0;
      end
      S_TM: sneg_r <= pn ^ w_neg_r[i_r];
      S_TMW: begin
        if (mul_done) begin
          acc_r[c_r] <= sneg_r ? acc_r[c_r] - ACC_W'(term) : acc_r[c_r] + ACC_W'(term);
          c_r        <= c_r + 1'b1;
          if (c_r == 2'd2 && i_r != I_LAST) i_r <= i_r + 1'b1;
        end
      end
      S_FIN: begin
        for (int k = 0; k < 3; k++) begin
          if (acc_r[k] > POS_MAX) begin
            res_r[k] <= POS_MAX[P_W-1:0];
          end else if (acc_r[k] < POS_MIN) begin
            res_r[k] <= POS_MIN[P_W-1:0];
          end else begin
            res_r[k] <= acc_r[k][P_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == S_POST && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_POST && out_free) begin
      out_status_r <= status_r;
      out_data_r   <= {res_r[2], res_r[1], res_r[0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

>>> rtl/core/olag_checker.sv
// ----------------------------------------------------------------------------
// olag_checker
// Port-level checks of the orbit interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module olag_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic [olag_pkg::IN_TD_W-1:0]  in_tdata,
  input wire logic [1:0]                    in_tuser,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [olag_pkg::OUT_TD_W-1:0] out_tdata,
  input wire logic [1:0]                    out_tuser
);
  import olag_pkg::*;

  logic in_fire;
  assign in_fire = in_tvalid && in_tready && (in_tdata == in_tdata) && (in_tuser == in_tuser);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // failed queries and non-query items carry zero positions when not ok
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata == '0))
    else $error("nonzero position with failing status");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("item accepted while one is in flight");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind orbit_lagrange_interpolator_top olag_checker u_olag_checker (.*);

`default_nettype wire
